### rtl/ba_pkg.sv
// Shared constants and types of the buddy allocator.
// Used by ba_engine and buddy_allocator; depends on nothing else.
package ba_pkg;

  // Pool geometry; the pool size is a power of two.
  localparam int unsigned POOL_UNITS = 1024;
  localparam int unsigned LEVELS     = $clog2(POOL_UNITS);
  localparam int unsigned IDX_W      = LEVELS + 1;
  localparam int unsigned LVL_W      = $clog2(LEVELS + 1);
  localparam int unsigned OFF_W      = LEVELS;

  // Word fields.
  localparam int unsigned OWNER_W = 8;
  localparam int unsigned REQ_W   = 12;
  localparam int unsigned BOFF_W  = 10;
  localparam int unsigned SZ_W    = (LEVELS + 1 > REQ_W + 1) ? LEVELS + 1 : REQ_W + 1;

  // Owner tag of a node that holds no block.
  localparam logic [OWNER_W-1:0] DASH_OWNER = 8'd45;

  typedef enum logic {
    FUNC_ALLOC = 1'b0,
    FUNC_FREE  = 1'b1
  } ba_func_e;

  // One tree node as stored in the node memory.
  typedef struct packed {
    logic               split;
    logic               used;
    logic [OWNER_W-1:0] owner;
  } ba_node_t;

  // Request handed to the engine.
  typedef struct packed {
    ba_func_e           func;
    logic [OWNER_W-1:0] owner;
    logic [REQ_W-1:0]   req;
    logic [SZ_W-1:0]    need;
  } ba_req_t;

  // Result of one request.
  typedef struct packed {
    logic             ok;
    logic [OFF_W-1:0] offset;
  } ba_res_t;

  // Engine status seen by the top level.
  typedef struct packed {
    logic idle;
    logic clearing;
  } ba_stat_t;

endpackage

### rtl/ba_engine.sv
// Tree walker of the buddy allocator: node memory plus the sequencer that
// reads, modifies and writes it back. Depends on ba_pkg.
module ba_engine (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  ba_pkg::ba_req_t req_i,
  output ba_pkg::ba_res_t res_o,
  output logic            res_valid_o,
  input  logic            res_take_i,
  output ba_pkg::ba_stat_t stat_o
);
  import ba_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_RD,
    S_EVAL,
    S_UP,
    S_MRD_L,
    S_MRD_R,
    S_MEVAL,
    S_DONE
  } state_e;

  localparam int unsigned MEM_DEPTH = 2 ** IDX_W;

  state_e             state_q, state_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic [LVL_W-1:0]   lvl_q, lvl_d;
  logic [OFF_W-1:0]   off_q, off_d;
  ba_func_e           func_q, func_d;
  logic [OWNER_W-1:0] owner_q, owner_d;
  logic [REQ_W-1:0]   req_q, req_d;
  logic [SZ_W-1:0]    need_q, need_d;
  logic               ok_q, ok_d;
  logic [OFF_W-1:0]   where_q, where_d;
  ba_node_t           left_q, left_d;
  logic [IDX_W-1:0]   clr_q, clr_d;

  // Node memory, one write and one registered read per cycle.
  ba_node_t         mem [MEM_DEPTH];
  ba_node_t         rdata_q;
  logic             we, re;
  logic [IDX_W-1:0] waddr, raddr;
  ba_node_t         wdata;

  logic [SZ_W-1:0]  size_w;
  logic [SZ_W-1:0]  req_ext;
  logic [IDX_W-1:0] lchild, rchild, parent;
  logic             at_leaf;

  assign size_w  = SZ_W'(POOL_UNITS) >> lvl_q;
  assign req_ext = SZ_W'(req_q);
  assign lchild  = {idx_q[IDX_W-2:0], 1'b1};
  assign rchild  = lchild + IDX_W'(1);
  assign parent  = IDX_W'((idx_q - IDX_W'(1)) >> 1);
  assign at_leaf = (lvl_q == LVL_W'(LEVELS));

  // Sequencer. Every write after the clear lands in an evaluate cycle and
  // every read is issued in a later cycle, so a node is never read while its
  // update is still in flight.
  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    lvl_d   = lvl_q;
    off_d   = off_q;
    func_d  = func_q;
    owner_d = owner_q;
    req_d   = req_q;
    need_d  = need_q;
    ok_d    = ok_q;
    where_d = where_q;
    left_d  = left_q;
    clr_d   = clr_q;
    we      = 1'b0;
    waddr   = idx_q;
    wdata   = rdata_q;
    re      = 1'b0;
    raddr   = idx_q;

    case (state_q)
      S_CLEAR: begin
        we    = 1'b1;
        waddr = clr_q;
        wdata = '{split: 1'b0, used: 1'b0, owner: DASH_OWNER};
        clr_d = clr_q + IDX_W'(1);
        if (&clr_q) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start_i) begin
          func_d  = req_i.func;
          owner_d = req_i.owner;
          req_d   = req_i.req;
          need_d  = req_i.need;
          idx_d   = '0;
          lvl_d   = '0;
          off_d   = '0;
          ok_d    = 1'b0;
          where_d = '0;
          state_d = S_RD;
        end
      end
      S_RD: begin
        re      = 1'b1;
        raddr   = idx_q;
        state_d = S_EVAL;
      end
      S_EVAL: begin
        if (func_q == FUNC_ALLOC) begin
          if (rdata_q.used || (size_w < req_ext)) begin
            state_d = S_UP;
          end else if ((size_w == need_q) && !rdata_q.split) begin
            we      = 1'b1;
            wdata   = '{split: 1'b0, used: 1'b1, owner: owner_q};
            ok_d    = 1'b1;
            where_d = off_q;
            state_d = S_DONE;
          end else if (!rdata_q.split && at_leaf) begin
            state_d = S_UP;
          end else begin
            // Split a free block if needed, then descend to the left child.
            if (!rdata_q.split) begin
              we    = 1'b1;
              wdata = '{split: 1'b1, used: 1'b0, owner: rdata_q.owner};
            end
            idx_d   = lchild;
            lvl_d   = lvl_q + LVL_W'(1);
            state_d = S_RD;
          end
        end else begin
          if (rdata_q.used && (rdata_q.owner == owner_q)) begin
            we      = 1'b1;
            wdata   = '{split: 1'b0, used: 1'b0, owner: DASH_OWNER};
            ok_d    = 1'b1;
            where_d = off_q;
            if (idx_q == '0) begin
              state_d = S_DONE;
            end else begin
              idx_d   = parent;
              state_d = S_MRD_L;
            end
          end else if (!rdata_q.split) begin
            state_d = S_UP;
          end else begin
            idx_d   = lchild;
            lvl_d   = lvl_q + LVL_W'(1);
            state_d = S_RD;
          end
        end
      end
      S_UP: begin
        // The subtree at idx holds no match: go to the next preorder subtree.
        if (idx_q == '0) begin
          state_d = S_DONE;
        end else if (idx_q[0]) begin
          idx_d   = idx_q + IDX_W'(1);
          off_d   = off_q + OFF_W'(size_w);
          state_d = S_RD;
        end else begin
          idx_d = parent;
          lvl_d = lvl_q - LVL_W'(1);
          off_d = off_q - OFF_W'(size_w);
        end
      end
      S_MRD_L: begin
        re      = 1'b1;
        raddr   = lchild;
        state_d = S_MRD_R;
      end
      S_MRD_R: begin
        re      = 1'b1;
        raddr   = rchild;
        state_d = S_MEVAL;
      end
      S_MEVAL: begin
        left_d = left_q;
        if (!left_q.used && !left_q.split && !rdata_q.used && !rdata_q.split) begin
          we    = 1'b1;
          wdata = '{split: 1'b0, used: 1'b0, owner: DASH_OWNER};
          if (idx_q == '0) begin
            state_d = S_DONE;
          end else begin
            idx_d   = parent;
            state_d = S_MRD_L;
          end
        end else begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (res_take_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // The left child's word arrives while the right one is being read.
    if (state_q == S_MRD_R) begin
      left_d = rdata_q;
    end
  end

  // State and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      ok_q    <= 1'b0;
      where_q <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      ok_q    <= ok_d;
      where_q <= where_d;
    end
  end

  // Walk context; no reset needed.
  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    lvl_q   <= lvl_d;
    off_q   <= off_d;
    func_q  <= func_d;
    owner_q <= owner_d;
    req_q   <= req_d;
    need_q  <= need_d;
    left_q  <= left_d;
  end

  // Node memory.
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_q <= mem[raddr];
    end
  end

  assign res_o       = '{ok: ok_q, offset: where_q};
  assign res_valid_o = (state_q == S_DONE);
  assign stat_o      = '{idle: (state_q == S_IDLE), clearing: (state_q == S_CLEAR)};

endmodule

### rtl/buddy_allocator.sv
// Buddy allocator over a pool of power-of-two units.
//
// Input stream (s_axis): tuser selects the operation (0 allocate, 1 free),
// tdata carries the owner tag and the requested size. Output stream
// (m_axis): tuser is the success flag, tdata the unit offset of the block
// taken or released (zero on failure). Each input word gives exactly one
// output word, in order.
//
// A request walks the node tree in preorder. Each node costs a read of the
// single node memory followed by an evaluate cycle; a free then, for each
// ancestor, reads the left child, reads the right child and evaluates the
// merge. One request is worked on at a time.
//
// After reset the node memory is cleared one entry per cycle, during which
// s_axis_tready stays low. The result sits in an output register; a stalled
// receiver holds it there while the next request is already accepted and
// walked, and that walk waits at its end until the register frees up.
module buddy_allocator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // owner_name[7:0], req_size[19:8], zero
  input  logic        s_axis_tuser,   // func
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // block_offset[9:0], zero
  output logic        m_axis_tuser    // success
);
  import ba_pkg::*;

  ba_req_t            req;
  ba_res_t            res;
  ba_stat_t           stat;
  logic               res_valid;
  logic               res_take;
  logic               start;
  logic [REQ_W-1:0]   req_m1;
  logic [SZ_W-1:0]    need;
  logic               m_valid_q, m_valid_d;
  logic               m_ok_q;
  logic [BOFF_W-1:0]  m_off_q;

  // Round the request up to a power of two; zero counts as one.
  always_comb begin
    req_m1 = (s_axis_tdata[19:8] == '0) ? '0 : s_axis_tdata[19:8] - REQ_W'(1);
    need   = SZ_W'(1);
    for (int i = 0; i < REQ_W; i++) begin
      if (req_m1[i]) begin
        need = SZ_W'(2) << i;
      end
    end
  end

  assign req = '{func:  ba_func_e'(s_axis_tuser),
                 owner: s_axis_tdata[7:0],
                 req:   s_axis_tdata[19:8],
                 need:  need};

  assign s_axis_tready = stat.idle;
  assign start         = s_axis_tvalid && s_axis_tready;

  ba_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .req_i       (req),
    .res_o       (res),
    .res_valid_o (res_valid),
    .res_take_i  (res_take),
    .stat_o      (stat)
  );

  // Output register.
  assign res_take = res_valid && (!m_valid_q || m_axis_tready);

  always_comb begin
    m_valid_d = m_valid_q;
    if (res_take) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      m_ok_q  <= res.ok;
      m_off_q <= BOFF_W'(res.offset);
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = m_ok_q;
  assign m_axis_tdata  = {{(16 - BOFF_W){1'b0}}, m_off_q};

`ifndef ASSERT_OFF
  // No request may enter while the node memory is being cleared.
  a_no_accept_in_clear : assert property (
    @(posedge clk_i) disable iff (!rst_ni) stat.clearing |-> !s_axis_tready)
    else $error("request accepted during memory clear");

  // A failed request reports offset zero.
  a_fail_offset_zero : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
    else $error("failed result carries a nonzero offset");

  // Handing a result to the output register frees the engine.
  a_idle_after_take : assert property (
    @(posedge clk_i) disable iff (!rst_ni) res_take |=> stat.idle)
    else $error("engine not idle after its result was taken");
`endif

endmodule
